// ===== src/assert_macros.svh =====
// assertion helpers used by sorted_priority_queue.sv
// all of them sample on the rising clock edge and are off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("spq assertion failed");
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rst_n, expr)
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_PEEK   = 2'd1,
		KIND_POP    = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	localparam int IdBits   = 16;
	localparam int PrioBits = 8;
	localparam int AgeBits  = 8;
	localparam int OccBits  = 5;

	typedef struct packed {
		logic [1:0]          kind;
		logic [PrioBits-1:0] priority_req;
		logic [AgeBits-1:0]  age;
		logic [IdBits-1:0]   target_id;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [IdBits-1:0]   entry_id;
		logic [PrioBits-1:0] entry_priority;
		logic [AgeBits-1:0]  entry_age;
		logic [OccBits-1:0]  occupancy;
	} rsp_t;

	// slot contents other than the priority
	typedef struct packed {
		logic [IdBits-1:0]  ident;
		logic [AgeBits-1:0] payload;
	} slot_data_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic              insert_en;
		logic              remove_en;
		logic [IdBits-1:0] target;
		slot_data_t        new_data;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none
module spq_cell import spq_pkg::*; #(
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire cell_cmd_t     cmd,
	input  wire logic [PW-1:0] new_prio,
	input  wire logic          occupied,
	input  wire logic          left_ge,
	input  wire logic [PW-1:0] left_prio,
	input  wire slot_data_t    left_data,
	input  wire logic [PW-1:0] right_prio,
	input  wire slot_data_t    right_data,
	input  wire logic          shift,
	output logic               ge,
	output logic               match,
	output logic [PW-1:0]      prio,
	output slot_data_t         data
);

	logic [PW-1:0] prio_q, prio_d;
	slot_data_t    data_q, data_d;

	// held entry ranks ahead of the new one (ties keep arrival order)
	assign ge    = occupied && (prio_q >= new_prio);
	assign match = occupied && (data_q.ident == cmd.target);
	assign prio  = prio_q;
	assign data  = data_q;

	always_comb begin
		prio_d = prio_q;
		data_d = data_q;
		if (cmd.insert_en && !ge) begin
			if (left_ge) begin
				prio_d = new_prio;
				data_d = cmd.new_data;
			end else begin
				prio_d = left_prio;
				data_d = left_data;
			end
		end else if (cmd.remove_en && shift) begin
			prio_d = right_prio;
			data_d = right_data;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		data_q <= data_d;
	end

endmodule
`default_nettype wire

// ===== src/spq_pick.sv =====
`default_nettype none
module spq_pick import spq_pkg::*; #(
	parameter int N  = 16,
	parameter int PW = 8
) (
	input  wire logic [N-1:0]  match,
	input  wire logic [PW-1:0] prio [N],
	input  wire slot_data_t    data [N],
	output logic [N-1:0]       shift,
	output logic               found,
	output logic [PW-1:0]      sel_prio,
	output slot_data_t         sel_data
);

	logic [N-1:0] first_hit;

	// a cell shifts when the removed slot is at or before it
	for (genvar i = 0; i < N; i++) begin : g_prefix
		assign shift[i] = |match[i:0];
	end

	assign first_hit = match & ~{shift[N-2:0], 1'b0};
	assign found     = shift[N-1];

	always_comb begin
		sel_prio = '0;
		sel_data = '0;
		for (int i = 0; i < N; i++) begin
			if (first_hit[i]) begin
				sel_prio = sel_prio | prio[i];
				sel_data = sel_data | data[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// a transferred request waits in the request register, then the step writes its response into the response register
// throughput: one request per cycle while responses are taken; a stalled response holds the step
// every operation, insert shift or remove shift included, finishes in the step
// reset clears the entry count, the id counter and both valid flags; slot contents stay undefined
`default_nettype none
`include "assert_macros.svh"
module sorted_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PRIO_BITS   = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// stored priority width: only the low min(PRIO_BITS, 8) bits of an 8 bit field survive
	localparam int PW = (PRIO_BITS < PrioBits) ? PRIO_BITS : PrioBits;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// request register and response register
	req_t  req_s1;
	logic  s1_valid_q;
	rsp_t  rsp_q;
	logic  rsp_valid_q;

	// queue bookkeeping
	logic [CW-1:0]     count_q, count_d;
	logic [IdBits-1:0] id_q, id_d;

	// step control
	logic      advance;
	logic      fire;
	logic      empty;
	logic      full;
	logic      ins, rm, pop_sel;
	status_t   st;
	rsp_t      rsp_d;
	cell_cmd_t cmd;
	logic [PW-1:0] new_prio;

	// chain wiring
	logic [PW-1:0]     cell_prio [QUEUE_DEPTH];
	slot_data_t        cell_data [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ge_v, match_v, occ_v, shift_v, pick_shift;
	logic              found;
	logic [PW-1:0]     sel_prio;
	slot_data_t        sel_data;

	// the step runs when the response register is free or being emptied
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign fire      = s1_valid_q && advance;
	assign req_stall = s1_valid_q && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign new_prio = req_s1.priority_req[PW-1:0];

	// broadcast to the cells, only live in the step cycle
	assign cmd.insert_en         = fire && ins;
	assign cmd.remove_en         = fire && rm;
	assign cmd.target            = req_s1.target_id;
	assign cmd.new_data.ident    = id_d;
	assign cmd.new_data.payload  = req_s1.age;

	// pop always removes the head, so every cell shifts
	assign shift_v = pop_sel ? '1 : pick_shift;

	// row of slots, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic          l_ge;
		logic [PW-1:0] l_prio, r_prio;
		slot_data_t    l_data, r_data;

		assign occ_v[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign l_ge   = 1'b1;
			assign l_prio = new_prio;
			assign l_data = cmd.new_data;
		end else begin : g_body
			assign l_ge   = ge_v[i-1];
			assign l_prio = cell_prio[i-1];
			assign l_data = cell_data[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_prio = cell_prio[i];
			assign r_data = cell_data[i];
		end else begin : g_inner
			assign r_prio = cell_prio[i+1];
			assign r_data = cell_data[i+1];
		end

		spq_cell #(.PW(PW)) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.new_prio   (new_prio),
			.occupied   (occ_v[i]),
			.left_ge    (l_ge),
			.left_prio  (l_prio),
			.left_data  (l_data),
			.right_prio (r_prio),
			.right_data (r_data),
			.shift      (shift_v[i]),
			.ge         (ge_v[i]),
			.match      (match_v[i]),
			.prio       (cell_prio[i]),
			.data       (cell_data[i])
		);
	end

	// first matching slot nearest the head, and the shift mask behind it
	spq_pick #(.N(QUEUE_DEPTH), .PW(PW)) u_pick (
		.match    (match_v),
		.prio     (cell_prio),
		.data     (cell_data),
		.shift    (pick_shift),
		.found    (found),
		.sel_prio (sel_prio),
		.sel_data (sel_data)
	);

	// operation decode and response fields
	always_comb begin
		st      = ST_OK;
		count_d = count_q;
		id_d    = id_q;
		ins     = 1'b0;
		rm      = 1'b0;
		pop_sel = 1'b0;
		rsp_d   = '0;
		case (req_s1.kind)
			KIND_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					id_d                 = id_q + IdBits'(1);
					ins                  = 1'b1;
					count_d              = count_q + CW'(1);
					rsp_d.entry_id       = id_d;
					rsp_d.entry_priority = PrioBits'(new_prio);
					rsp_d.entry_age      = req_s1.age;
				end
			end
			KIND_PEEK, KIND_POP: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					rsp_d.entry_id       = cell_data[0].ident;
					rsp_d.entry_priority = PrioBits'(cell_prio[0]);
					rsp_d.entry_age      = cell_data[0].payload;
					if (req_s1.kind == KIND_POP) begin
						rm      = 1'b1;
						pop_sel = 1'b1;
						count_d = count_q - CW'(1);
					end
				end
			end
			KIND_REMOVE: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (!found) begin
					st = ST_NOTFOUND;
				end else begin
					rm                   = 1'b1;
					count_d              = count_q - CW'(1);
					rsp_d.entry_id       = sel_data.ident;
					rsp_d.entry_priority = PrioBits'(sel_prio);
					rsp_d.entry_age      = sel_data.payload;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
		rsp_d.status    = st;
		rsp_d.occupancy = OccBits'(count_d);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			id_q        <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
				id_q        <= id_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	`SPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(QUEUE_DEPTH))
	`SPQ_ASSERT_NEXT(a_step_gives_rsp, clk, arst_n, fire, rsp_valid_q)
	`SPQ_ASSERT_NEXT(a_state_holds, clk, arst_n, !fire, $stable(count_q) && $stable(id_q))
	`SPQ_ASSERT_SAME(a_full_refusal, clk, arst_n, fire && st == ST_FULL, full)
	`SPQ_ASSERT_SAME(a_empty_status, clk, arst_n, fire && st == ST_EMPTY, empty)

endmodule
`default_nettype wire

// ===== bench/sorted_priority_queue_test.sv =====
`default_nettype none
module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int HALF_PERIOD    = 6;
	localparam int HOLD_CYCLES    = 90;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int PRINT_LIMIT    = 60;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow copy of the queue contents
	logic [PrioBits-1:0] shadow_prio[DEPTH];
	logic [IdBits-1:0]   shadow_ident[DEPTH];
	logic [AgeBits-1:0]  shadow_payload[DEPTH];
	int                  shadow_held = 0;
	logic [IdBits-1:0]   last_issued_id = '0;

	rsp_t pending_rsp[$];
	int   mismatch_count = 0;
	int   idle_cycles = 0;
	bit   quiet = 1'b0;
	bit   hold_go = 1'b0;
	int   hold_left = 0;

	sorted_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("error: %s", msg);
		end
	endtask

	// applies one accepted request to the shadow queue and queues its response
	task automatic apply_request(input req_t r);
		rsp_t res;
		int   pos;
		int   i;
		res = '0;
		if (r.kind == KIND_INSERT) begin
			if (shadow_held >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				last_issued_id = last_issued_id + 1'b1;
				pos = 0;
				while (pos < shadow_held && shadow_prio[pos] >= r.priority_req) pos++;
				for (i = shadow_held; i > pos; i--) begin
					shadow_prio[i]    = shadow_prio[i-1];
					shadow_ident[i]   = shadow_ident[i-1];
					shadow_payload[i] = shadow_payload[i-1];
				end
				shadow_prio[pos]    = r.priority_req;
				shadow_ident[pos]   = last_issued_id;
				shadow_payload[pos] = r.age;
				shadow_held++;
				res.status         = ST_OK;
				res.entry_id       = last_issued_id;
				res.entry_priority = r.priority_req;
				res.entry_age      = r.age;
			end
		end else if (shadow_held == 0) begin
			res.status = ST_EMPTY;
		end else begin
			pos = 0;
			if (r.kind == KIND_REMOVE) begin
				while (pos < shadow_held && shadow_ident[pos] != r.target_id) pos++;
			end
			if (pos >= shadow_held) begin
				res.status = ST_NOTFOUND;
			end else begin
				res.status         = ST_OK;
				res.entry_id       = shadow_ident[pos];
				res.entry_priority = shadow_prio[pos];
				res.entry_age      = shadow_payload[pos];
				if (r.kind != KIND_PEEK) begin
					for (i = pos; i + 1 < shadow_held; i++) begin
						shadow_prio[i]    = shadow_prio[i+1];
						shadow_ident[i]   = shadow_ident[i+1];
						shadow_payload[i] = shadow_payload[i+1];
					end
					shadow_held--;
				end
			end
		end
		res.occupancy = OccBits'(shadow_held);
		pending_rsp.push_back(res);
	endtask

	// offers one request and returns once it has been transferred
	task automatic send_request(input req_t r);
		if (!quiet && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		apply_request(r);
	endtask

	task automatic send_op(input kind_t k, input int prio, input int age, input int target);
		req_t r;
		r.kind         = k;
		r.priority_req = PrioBits'(prio);
		r.age          = AgeBits'(age);
		r.target_id    = IdBits'(target);
		send_request(r);
	endtask

	task automatic wait_drained;
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic random_request(output req_t r, input bit grow);
		int roll;
		roll = $urandom_range(99);
		r.priority_req = ($urandom_range(1) == 1) ? PrioBits'($urandom) :
			(($urandom_range(1) == 1) ? PrioBits'($urandom_range(3)) :
			PrioBits'($urandom_range(255, 252)));
		r.age       = AgeBits'($urandom);
		r.target_id = IdBits'($urandom);
		if (roll < (grow ? 55 : 20)) begin
			r.kind = KIND_INSERT;
		end else if (roll < (grow ? 65 : 35)) begin
			r.kind = KIND_PEEK;
		end else if (roll < (grow ? 82 : 68)) begin
			r.kind = KIND_POP;
		end else begin
			r.kind = KIND_REMOVE;
			// mostly aim at an id that is held, sometimes at or just past the newest issued id
			if (shadow_held > 0 && $urandom_range(99) < 75) begin
				r.target_id = shadow_ident[$urandom_range(shadow_held - 1)];
			end else if ($urandom_range(1) == 1) begin
				r.target_id = last_issued_id + IdBits'($urandom_range(3));
			end
		end
	endtask

	task automatic test_empty;
		send_op(KIND_PEEK, 8'h00, 8'h00, 16'h0000);
		send_op(KIND_POP, 8'hff, 8'hff, 16'hffff);
		send_op(KIND_REMOVE, 8'h5a, 8'ha5, 16'h0001);
	endtask

	task automatic test_order;
		send_op(KIND_INSERT, 8'h00, 8'h00, 16'hffff);
		send_op(KIND_INSERT, 8'hff, 8'hff, 16'h0000);
		send_op(KIND_INSERT, 8'h80, 8'h01, 16'h0000);
		send_op(KIND_INSERT, 8'h80, 8'h02, 16'h0000);
		send_op(KIND_INSERT, 8'h80, 8'h03, 16'h0000);
		send_op(KIND_PEEK, 8'h00, 8'h00, 16'h0000);
		repeat (6) send_op(KIND_POP, 8'h00, 8'h00, 16'h0000);
	endtask

	task automatic test_remove;
		send_op(KIND_INSERT, 8'h10, 8'haa, 16'h0000);
		send_op(KIND_INSERT, 8'h20, 8'hbb, 16'h0000);
		send_op(KIND_INSERT, 8'h30, 8'hcc, 16'h0000);
		send_op(KIND_REMOVE, 8'h00, 8'h00, last_issued_id - 1'b1);
		send_op(KIND_REMOVE, 8'h00, 8'h00, 16'hffff);
		send_op(KIND_REMOVE, 8'h00, 8'h00, last_issued_id);
		send_op(KIND_REMOVE, 8'h00, 8'h00, last_issued_id - 2'd2);
		send_op(KIND_REMOVE, 8'h00, 8'h00, last_issued_id);
	endtask

	task automatic test_full;
		repeat (DEPTH) send_op(KIND_INSERT, $urandom_range(255), $urandom_range(255), 0);
		send_op(KIND_INSERT, 8'hff, 8'hff, 16'h0000);
		send_op(KIND_PEEK, 8'h00, 8'h00, 16'h0000);
		repeat (DEPTH + 1) send_op(KIND_POP, 8'h00, 8'h00, 16'h0000);
	endtask

	// responses held back while requests keep coming, then a full drain
	task automatic test_backpressure;
		req_t r;
		hold_go = 1'b1;
		repeat (40) begin
			random_request(r, 1'b1);
			send_request(r);
		end
		req_valid <= 1'b0;
		wait (!hold_go && hold_left == 0);
		wait_drained;
	endtask

	task automatic test_random;
		req_t r;
		int   n;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 500 && n < 800);
			random_request(r, ((n / 100) % 2) == 0);
			send_request(r);
		end
		quiet = 1'b0;
	endtask

	// response side: random stall, or a long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !quiet && ($urandom_range(99) < 14);
			end
		end
	end

	// compare every response transfer with the oldest expected response
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report($sformatf("response with none expected: %h", rsp));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report($sformatf("status %0d, expected %0d", rsp.status, want.status));
				if (rsp.entry_id !== want.entry_id)
					report($sformatf("entry_id %h, expected %h", rsp.entry_id, want.entry_id));
				if (rsp.entry_priority !== want.entry_priority)
					report($sformatf("entry_priority %h, expected %h",
						rsp.entry_priority, want.entry_priority));
				if (rsp.entry_age !== want.entry_age)
					report($sformatf("entry_age %h, expected %h", rsp.entry_age, want.entry_age));
				if (rsp.occupancy !== want.occupancy)
					report($sformatf("occupancy %0d, expected %0d",
						rsp.occupancy, want.occupancy));
			end
		end
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_priority_queue_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty;
		test_order;
		test_remove;
		test_full;
		wait_drained;
		test_backpressure;
		test_random;
		wait_drained;
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sorted_priority_queue_test: PASS");
		end else begin
			$display("sorted_priority_queue_test: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sorted_priority_queue.f =====
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/spq_pick.sv
src/sorted_priority_queue.sv
bench/sorted_priority_queue_test.sv
